// ===== rtl/core/bpef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpef_pkg
// Shared types, constants and the microprogram of the bandpass envelope
// follower.
// ----------------------------------------------------------------------------
package bpef_pkg;

    localparam int RATE_FRAC    = 24;
    localparam int RATE_BITS    = RATE_FRAC + 1;
    localparam int CFG_IDX_BITS = 3;
    localparam int PC_BITS      = 4;

    localparam logic [RATE_BITS-1:0] RATE_ONE = {1'b1, {RATE_FRAC{1'b0}}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BAND_GAIN    = 3'd0,
        REG_FEEDBACK_ONE = 3'd1,
        REG_FEEDBACK_TWO = 3'd2,
        REG_ATTACK_RATE  = 3'd3,
        REG_DECAY_RATE   = 3'd4
    } cfg_reg_t;

    // Coefficient-side multiplier operand
    typedef enum logic [1:0] {
        CS_GAIN,
        CS_FB1,
        CS_FB2,
        CS_RATE
    } coef_sel_t;

    // Sample-side multiplier operand
    typedef enum logic [1:0] {
        BS_XDIFF,
        BS_Y1,
        BS_Y2,
        BS_DIFF
    } samp_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_INIT,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_TAKE,
        ACT_ROUND,
        ACT_PREP,
        ACT_ENV,
        ACT_EMIT
    } act_t;

    typedef struct packed {
        act_t               act;
        coef_sel_t          coef_sel;
        logic               hi_half;
        samp_sel_t          samp_sel;
        logic               mul_en;
        acc_op_t            acc_op;
        logic               acc_shift;
        logic [PC_BITS-1:0] next_step;
    } ctl_word_t;

    localparam logic [PC_BITS-1:0] STEP_TAKE = '0;

    function automatic ctl_word_t cw(act_t act, coef_sel_t cs, logic hi, samp_sel_t bs,
                                     logic mul, acc_op_t op, logic sh,
                                     logic [PC_BITS-1:0] nxt);
        ctl_word_t w;
        w.act       = act;
        w.coef_sel  = cs;
        w.hi_half   = hi;
        w.samp_sel  = bs;
        w.mul_en    = mul;
        w.acc_op    = op;
        w.acc_shift = sh;
        w.next_step = nxt;
        return w;
    endfunction

    // Microprogram. Each filter multiply in one step is accumulated in the next one;
    // the high coefficient half lands shifted up by the half width.
    function automatic ctl_word_t ucode(logic [PC_BITS-1:0] pc);
        ctl_word_t w;
        case (pc)
            4'd0:    w = cw(ACT_TAKE,  CS_GAIN, 1'b0, BS_XDIFF, 1'b0, ACC_HOLD, 1'b0, 4'd1);
            4'd1:    w = cw(ACT_NONE,  CS_GAIN, 1'b0, BS_XDIFF, 1'b1, ACC_INIT, 1'b0, 4'd2);
            4'd2:    w = cw(ACT_NONE,  CS_GAIN, 1'b1, BS_XDIFF, 1'b1, ACC_ADD,  1'b0, 4'd3);
            4'd3:    w = cw(ACT_NONE,  CS_FB1,  1'b0, BS_Y1,    1'b1, ACC_ADD,  1'b1, 4'd4);
            4'd4:    w = cw(ACT_NONE,  CS_FB1,  1'b1, BS_Y1,    1'b1, ACC_SUB,  1'b0, 4'd5);
            4'd5:    w = cw(ACT_NONE,  CS_FB2,  1'b0, BS_Y2,    1'b1, ACC_SUB,  1'b1, 4'd6);
            4'd6:    w = cw(ACT_NONE,  CS_FB2,  1'b1, BS_Y2,    1'b1, ACC_SUB,  1'b0, 4'd7);
            4'd7:    w = cw(ACT_NONE,  CS_GAIN, 1'b0, BS_XDIFF, 1'b0, ACC_SUB,  1'b1, 4'd8);
            4'd8:    w = cw(ACT_ROUND, CS_GAIN, 1'b0, BS_XDIFF, 1'b0, ACC_HOLD, 1'b0, 4'd9);
            4'd9:    w = cw(ACT_PREP,  CS_GAIN, 1'b0, BS_XDIFF, 1'b0, ACC_HOLD, 1'b0, 4'd10);
            4'd10:   w = cw(ACT_NONE,  CS_RATE, 1'b0, BS_DIFF,  1'b1, ACC_HOLD, 1'b0, 4'd11);
            4'd11:   w = cw(ACT_ENV,   CS_GAIN, 1'b0, BS_XDIFF, 1'b0, ACC_HOLD, 1'b0, 4'd12);
            4'd12:   w = cw(ACT_EMIT,  CS_GAIN, 1'b0, BS_XDIFF, 1'b0, ACC_HOLD, 1'b0,
                            STEP_TAKE);
            default: w = cw(ACT_NONE,  CS_GAIN, 1'b0, BS_XDIFF, 1'b0, ACC_HOLD, 1'b0,
                            STEP_TAKE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/bpef_useq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpef_useq
// Step counter and program ROM; waiting steps hold until their handshake.
// ----------------------------------------------------------------------------
module bpef_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_free,
    output bpef_pkg::ctl_word_t ctl
);
    import bpef_pkg::*;

    logic [PC_BITS-1:0] pc_reg;
    logic [PC_BITS-1:0] pc_next;
    logic               hold;

    assign ctl  = ucode(pc_reg);
    assign hold = ((ctl.act == ACT_TAKE) && !in_valid) ||
                  ((ctl.act == ACT_EMIT) && !out_free);

    always_comb
    begin
        pc_next = hold ? pc_reg : ctl.next_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_TAKE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/core/bandpass_envelope_follower.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bandpass_envelope_follower
// Bandpass biquad followed by an attack/decay envelope smoother.
// ----------------------------------------------------------------------------
// Each accepted sample runs through the whole microprogram before its envelope
// item appears on the output register, and no new sample is taken until that
// item has been emitted. The microprogram drives one shared multiplier of 26 by
// SAMPLE_BITS+1 bits that runs seven multiplies per sample (each coefficient, up
// to Q2.30, split in two halves, then the envelope rate), plus rounding, envelope
// and output steps. A stalled output holds the sequencer on its output step.
// Configuration writes are taken in any cycle and must only be issued while no
// sample is in flight.
module bandpass_envelope_follower #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [SAMPLE_BITS-2:0]              envelope,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpef_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [((COEF_BITS > bpef_pkg::RATE_BITS) ? COEF_BITS
                   : bpef_pkg::RATE_BITS)-1:0] cfg_data
);
    import bpef_pkg::*;

    localparam int S    = SAMPLE_BITS;
    localparam int C    = COEF_BITS;
    localparam int F    = C - 2;
    localparam int CW   = C + 1;
    localparam int HALF = (CW + 1) / 2;
    localparam int HIW  = CW - HALF;
    localparam int MA   = (HALF + 1 > RATE_BITS + 1) ? HALF + 1 : RATE_BITS + 1;
    localparam int BW   = S + 1;
    localparam int PW   = MA + BW;
    localparam int ACC  = (S + C + 2 > 64) ? 64 : S + C + 2;
    localparam int EW   = (PW + HALF > ACC) ? PW + HALF : ACC;
    localparam int QW   = ACC - F;
    localparam int QX   = (QW > S) ? QW : S;

    localparam logic signed [QX-1:0] Q_HI = {{(QX-S+1){1'b0}}, {(S-1){1'b1}}};
    localparam logic signed [QX-1:0] Q_LO = {{(QX-S+1){1'b1}}, {(S-1){1'b0}}};
    localparam logic [S-2:0]         SMAX = {(S-1){1'b1}};
    localparam logic signed [S-1:0]  SMIN = {1'b1, {(S-1){1'b0}}};

    // configuration
    logic [C-3:0]          band_gain_reg;
    logic signed [C-1:0]   feedback_one_reg;
    logic signed [C-2:0]   feedback_two_reg;
    logic [RATE_BITS-1:0]  attack_rate_reg;
    logic [RATE_BITS-1:0]  decay_rate_reg;

    // filter and envelope state
    logic signed [S-1:0]   x1_reg;
    logic signed [S-1:0]   x2_reg;
    logic signed [S-1:0]   y1_reg;
    logic signed [S-1:0]   y2_reg;
    logic [S-2:0]          env_reg;

    // working registers
    logic signed [S-1:0]   sample_hold_reg;
    logic signed [BW-1:0]  xdiff_reg;
    logic signed [PW-1:0]  prod_reg;
    logic [ACC-1:0]        acc_reg;
    logic signed [S-1:0]   d_reg;
    logic [RATE_BITS-1:0]  rate_reg;
    logic [S-2:0]          out_reg;
    logic                  out_valid_reg;

    ctl_word_t             ctl;
    logic                  out_free;
    logic                  in_accept;

    logic signed [CW-1:0]  coef;
    logic signed [MA-1:0]  a_op;
    logic signed [BW-1:0]  b_op;
    logic signed [EW-1:0]  prod_ext;
    logic signed [EW-1:0]  prod_sh;
    logic [ACC-1:0]        term;
    logic signed [QW-1:0]  q;
    logic signed [QX-1:0]  q_ext;
    logic signed [S-1:0]   y_sat;
    logic signed [S-1:0]   y_neg;
    logic [S-2:0]          mag;
    logic [RATE_BITS-1:0]  rate_pick;
    logic signed [PW-1:0]  prod_rnd;
    logic signed [PW-1:0]  delta_full;
    logic signed [S+1:0]   env_sum;
    logic [S-2:0]          env_new;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (ctl.act != ACT_TAKE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign envelope  = out_reg;

    bpef_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .ctl      (ctl)
    );

    // multiplier operands
    always_comb
    begin
        case (ctl.coef_sel)
            CS_GAIN: coef = $signed({3'b000, band_gain_reg});
            CS_FB1:  coef = {feedback_one_reg[C-1], feedback_one_reg};
            CS_FB2:  coef = {{2{feedback_two_reg[C-2]}}, feedback_two_reg};
            default: coef = '0;
        endcase
        if (ctl.coef_sel == CS_RATE)
        begin
            a_op = $signed({{(MA-RATE_BITS){1'b0}}, rate_reg});
        end
        else if (ctl.hi_half)
        begin
            a_op = $signed({{(MA-HIW){coef[CW-1]}}, coef[CW-1:HALF]});
        end
        else
        begin
            a_op = $signed({{(MA-HALF){1'b0}}, coef[HALF-1:0]});
        end
        case (ctl.samp_sel)
            BS_XDIFF: b_op = xdiff_reg;
            BS_Y1:    b_op = {y1_reg[S-1], y1_reg};
            BS_Y2:    b_op = {y2_reg[S-1], y2_reg};
            default:  b_op = {d_reg[S-1], d_reg};
        endcase
    end

    // accumulator term: previous product, optionally weighted by 2^HALF
    always_comb
    begin
        prod_ext = EW'(prod_reg);
        prod_sh  = ctl.acc_shift ? (prod_ext <<< HALF) : prod_ext;
        term     = prod_sh[ACC-1:0];
    end

    // round to the sample grid and saturate
    always_comb
    begin
        q     = $signed(acc_reg[ACC-1:F]);
        q_ext = QX'(q);
        if (q_ext > Q_HI)
        begin
            y_sat = $signed({1'b0, SMAX});
        end
        else if (q_ext < Q_LO)
        begin
            y_sat = SMIN;
        end
        else
        begin
            y_sat = q_ext[S-1:0];
        end
    end

    // rectify the newest output and pick the smoothing rate
    always_comb
    begin
        y_neg = -y1_reg;
        if (!y1_reg[S-1])
        begin
            mag = y1_reg[S-2:0];
        end
        else if (y1_reg == SMIN)
        begin
            mag = SMAX;
        end
        else
        begin
            mag = y_neg[S-2:0];
        end
        rate_pick = (mag > env_reg) ? attack_rate_reg : decay_rate_reg;
        if (rate_pick > RATE_ONE)
        begin
            rate_pick = RATE_ONE;
        end
    end

    // envelope step with round-half-up and clamp
    always_comb
    begin
        prod_rnd   = prod_reg + (PW'(1) <<< (RATE_FRAC - 1));
        delta_full = prod_rnd >>> RATE_FRAC;
        env_sum    = $signed({3'b000, env_reg}) + $signed(delta_full[S+1:0]);
        if (env_sum < 0)
        begin
            env_new = '0;
        end
        else if (env_sum > $signed({3'b000, SMAX}))
        begin
            env_new = SMAX;
        end
        else
        begin
            env_new = env_sum[S-2:0];
        end
    end

    // configuration and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_gain_reg    <= '0;
            feedback_one_reg <= '0;
            feedback_two_reg <= '0;
            attack_rate_reg  <= RATE_ONE;
            decay_rate_reg   <= RATE_ONE;
            x1_reg           <= '0;
            x2_reg           <= '0;
            y1_reg           <= '0;
            y2_reg           <= '0;
            env_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BAND_GAIN:    band_gain_reg    <= cfg_data[C-3:0];
                    REG_FEEDBACK_ONE: feedback_one_reg <= $signed(cfg_data[C-1:0]);
                    REG_FEEDBACK_TWO: feedback_two_reg <= $signed(cfg_data[C-2:0]);
                    REG_ATTACK_RATE:  attack_rate_reg  <= cfg_data[RATE_BITS-1:0];
                    REG_DECAY_RATE:   decay_rate_reg   <= cfg_data[RATE_BITS-1:0];
                    default:          ;
                endcase
            end
            if (ctl.act == ACT_ROUND)
            begin
                x2_reg <= x1_reg;
                x1_reg <= sample_hold_reg;
                y2_reg <= y1_reg;
                y1_reg <= y_sat;
            end
            if (ctl.act == ACT_ENV)
            begin
                env_reg <= env_new;
            end
            if ((ctl.act == ACT_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_hold_reg <= sample;
            xdiff_reg       <= {sample[S-1], sample} - {x2_reg[S-1], x2_reg};
        end
        if (ctl.mul_en)
        begin
            prod_reg <= a_op * b_op;
        end
        case (ctl.acc_op)
            ACC_INIT: acc_reg <= ACC'(1) << (F - 1);
            ACC_ADD:  acc_reg <= acc_reg + term;
            ACC_SUB:  acc_reg <= acc_reg - term;
            default:  ;
        endcase
        if (ctl.act == ACT_PREP)
        begin
            d_reg    <= $signed({1'b0, mag}) - $signed({1'b0, env_reg});
            rate_reg <= rate_pick;
        end
        if ((ctl.act == ACT_EMIT) && out_free)
        begin
            out_reg <= env_reg;
        end
    end

    // a result only appears from the output step
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(ctl.act == ACT_EMIT))
        else $error("output valid rose outside the output step");

    // an accepted sample starts the filter program in the next cycle
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (ctl.acc_op == ACC_INIT && ctl.mul_en))
        else $error("accepted sample did not start the filter program");

    // a completed output step returns to waiting for a sample
    a_return: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.act == ACT_EMIT && out_free) |=> (ctl.act == ACT_TAKE))
        else $error("sequencer did not return after delivering a result");

    // the envelope multiply never sees a rate above one
    a_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.act == ACT_ENV) |-> ($past(rate_reg) <= RATE_ONE))
        else $error("envelope rate above one");

endmodule

// ===== bench/bandpass_envelope_follower_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bandpass_envelope_follower_tb
// Drives audio samples through the bandpass envelope follower under several
// coefficient sets and handshake pacing modes. A bit-true model of the biquad
// and the attack/decay smoother predicts every envelope item. Each received
// item is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module bandpass_envelope_follower_tb;

    import bpef_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     RESET_CYCLES = 10;
    localparam int     SETTLE       = 20;
    localparam int     CYCLE_LIMIT  = 600000;
    localparam int     PHASES       = 12;
    localparam int     PHASE_ITEMS  = 138;

    localparam longint SAMP_HI      = 64'sd8388607;
    localparam longint SAMP_LO      = -64'sd8388608;
    localparam longint FILT_HALF    = 64'sd1 << 29;
    localparam longint ENV_HALF     = 64'sd1 << 23;

    // indexes past the last register; writes there must leave all state alone
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd5;

    localparam int GAP_PCT  = 45;
    localparam int MIX_PCT  = 22;

    typedef enum int {
        PACE_FREE,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } pace_t;

    typedef enum int {
        COEF_RESONANT,
        COEF_RAW,
        COEF_EDGE
    } coef_kind_t;

    class band_envelope_tracker;
        logic        [29:0] gain;
        logic signed [31:0] fb_one;
        logic signed [30:0] fb_two;
        logic        [24:0] rate_up;
        logic        [24:0] rate_down;
        logic signed [23:0] x_one;
        logic signed [23:0] x_two;
        logic signed [23:0] y_one;
        logic signed [23:0] y_two;
        logic        [22:0] level;
        logic        [22:0] envelope_due[$];
        int                 errors;

        function new();
            gain      = '0;
            fb_one    = '0;
            fb_two    = '0;
            rate_up   = RATE_ONE;
            rate_down = RATE_ONE;
            x_one     = '0;
            x_two     = '0;
            y_one     = '0;
            y_two     = '0;
            level     = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
            case (idx)
                REG_BAND_GAIN:    gain      = data[29:0];
                REG_FEEDBACK_ONE: fb_one    = data;
                REG_FEEDBACK_TWO: fb_two    = data[30:0];
                REG_ATTACK_RATE:  rate_up   = data[24:0];
                REG_DECAY_RATE:   rate_down = data[24:0];
                default:          ;
            endcase
        endfunction

        function void take_sample(logic signed [23:0] x);
            longint g_l;
            longint a1_l;
            longint a2_l;
            longint acc;
            longint y;
            longint r;
            longint d;
            longint rate;
            longint env;
            g_l  = longint'(gain);
            a1_l = longint'(fb_one);
            a2_l = longint'(fb_two);
            acc  = g_l * (longint'(x) - longint'(x_two)) - a1_l * longint'(y_one)
                   - a2_l * longint'(y_two) + FILT_HALF;
            y = acc >>> 30;
            if (y > SAMP_HI)
                y = SAMP_HI;
            else if (y < SAMP_LO)
                y = SAMP_LO;
            x_two = x_one;
            x_one = x;
            y_two = y_one;
            y_one = y[23:0];

            r = (y < 0) ? -y : y;
            if (r > SAMP_HI)
                r = SAMP_HI;
            env  = longint'(level);
            // a tie takes the decay rate, which keeps the level where it is
            rate = (r > env) ? longint'(rate_up) : longint'(rate_down);
            if (rate > longint'(RATE_ONE))
                rate = longint'(RATE_ONE);
            d   = r - env;
            env = env + ((d * rate + ENV_HALF) >>> 24);
            if (env < 0)
                env = 0;
            else if (env > SAMP_HI)
                env = SAMP_HI;
            level = env[22:0];
            envelope_due.push_back(level);
        endfunction

        function void check_envelope(logic [22:0] got);
            logic [22:0] want;
            if (envelope_due.size() == 0)
            begin
                $display("%0t: envelope item %0d arrived with none expected", $time, got);
                errors++;
            end
            else
            begin
                want = envelope_due.pop_front();
                if (got !== want)
                begin
                    $display("%0t: envelope mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [23:0]       sample    = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic        [22:0]       envelope;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic        [31:0]       cfg_data  = '0;

    band_envelope_tracker     tracker;
    int                       gap_pct   = 0;
    int                       stall_pct = 0;
    int                       cycles    = 0;
    logic signed [23:0]       last_sample = '0;

    bandpass_envelope_follower u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .envelope  (envelope),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("bandpass_envelope_follower_tb: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // observe every handshake at the edge where it completes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                tracker.take_sample(sample);
            if (out_valid && !out_stall)
                tracker.check_envelope(envelope);
        end
    end

    task automatic send_sample(logic signed [23:0] x);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= x;
        last_sample = x;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // leaves cfg_valid high; close_cfg drops it once the burst is done
    task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic close_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.envelope_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_pace(pace_t mode);
        case (mode)
            PACE_FREE:        begin gap_pct = 0;       stall_pct = 0;       end
            PACE_SEND_GAPS:   begin gap_pct = GAP_PCT; stall_pct = 0;       end
            PACE_RECV_STALLS: begin gap_pct = 0;       stall_pct = GAP_PCT; end
            default:          begin gap_pct = MIX_PCT; stall_pct = MIX_PCT; end
        endcase
    endtask

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'(RATE_ONE);
            default: return 32'h01FF_FFFF;
        endcase
    endfunction

    task automatic program_coefs(coef_kind_t kind);
        logic [31:0] g;
        logic [31:0] a1;
        logic [31:0] a2;
        logic [31:0] up;
        logic [31:0] down;
        case (kind)
            COEF_RESONANT:
            begin
                // stable pole pair, constant-peak gain (1 - a2) / 2
                a2 = $urandom_range(32'h2000_0000, 32'h3FFF_0000);
                a1 = $urandom_range(0, 32'h4000_0000 + a2 - 32'h0001_0000);
                if ($urandom_range(1))
                    a1 = -a1;
                g    = (32'h4000_0000 - a2) >> 1;
                up   = $urandom_range(32'h0004_0000, 32'(RATE_ONE));
                down = $urandom_range(0, 32'h0010_0000);
            end
            COEF_RAW:
            begin
                g    = $urandom();
                a1   = $urandom();
                a2   = $urandom();
                up   = $urandom_range(0, 32'h01FF_FFFF);
                down = $urandom_range(0, 32'h01FF_FFFF);
            end
            default:
            begin
                g    = $urandom_range(1) ? 32'h3FFF_FFFF : 32'h0000_0000;
                a1   = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                a2   = $urandom_range(1) ? 32'h3FFF_FFFF : 32'h4000_0000;
                up   = pick_rate();
                down = pick_rate();
            end
        endcase
        if ($urandom_range(2) == 0)
            set_reg(REG_SPARE_LO + CFG_IDX_BITS'($urandom_range(2)), $urandom());
        set_reg(REG_BAND_GAIN, g);
        set_reg(REG_FEEDBACK_ONE, a1);
        set_reg(REG_FEEDBACK_TWO, a2);
        set_reg(REG_ATTACK_RATE, up);
        set_reg(REG_DECAY_RATE, down);
        close_cfg();
    endtask

    function automatic logic signed [23:0] pick_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 24'($urandom());
        else if (roll < 80)
            return 24'($signed($urandom_range(0, 8191)) - 4096);
        else if (roll < 90)
        begin
            case ($urandom_range(3))
                0:       return 24'sh7F_FFFF;
                1:       return 24'sh80_0000;
                2:       return 24'sh00_0000;
                default: return 24'shFF_FFFF;
            endcase
        end
        return last_sample;
    endfunction

    initial
    begin
        tracker = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: zero gain holds the envelope at zero
        send_sample(24'sh7F_FFFF);
        send_sample(24'sh80_0000);
        drain();

        // unity-ish gain with masked writes; attack above one acts as one
        set_reg(REG_SPARE_LO, 32'hDEAD_BEEF);
        set_reg(REG_BAND_GAIN, 32'hFFFF_FFFF);
        set_reg(REG_FEEDBACK_ONE, 32'h0000_0000);
        set_reg(REG_FEEDBACK_TWO, 32'h8000_0000);
        set_reg(REG_ATTACK_RATE, 32'hFFFF_FFFF);
        set_reg(REG_DECAY_RATE, 32'(RATE_ONE));
        close_cfg();
        send_sample(24'sh00_0000);
        send_sample(24'sh80_0000);
        send_sample(24'sh7F_FFFF);
        send_sample(24'sh7F_FFFF);
        send_sample(24'sh80_0000);
        send_sample(24'shFF_FFFF);
        send_sample(24'sh00_0001);
        send_sample(24'sh00_0000);
        drain();

        // frozen decay: the second equal-magnitude output leaves the level put
        set_reg(REG_ATTACK_RATE, 32'(RATE_ONE));
        set_reg(REG_DECAY_RATE, 32'd0);
        close_cfg();
        send_sample(24'sd0);
        send_sample(24'sd0);
        send_sample(24'sd1000);
        send_sample(24'sd0);
        send_sample(24'sd2000);
        drain();

        // extreme feedback, frozen attack
        set_reg(REG_BAND_GAIN, 32'h0010_0000);
        set_reg(REG_FEEDBACK_ONE, 32'h8000_0000);
        set_reg(REG_FEEDBACK_TWO, 32'h3FFF_FFFF);
        set_reg(REG_ATTACK_RATE, 32'd0);
        set_reg(REG_DECAY_RATE, 32'h0100_0001);
        close_cfg();
        send_sample(24'sh7F_FFFF);
        send_sample(24'sh80_0000);
        send_sample(24'sh12_3456);
        send_sample(24'sh00_0000);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            program_coefs(coef_kind_t'(p % 3));
            set_pace(pace_t'(p % 4));
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(pick_sample());
            drain();
        end

        if (tracker.errors == 0)
            $display("bandpass_envelope_follower_tb: done, clean");
        else
            $display("bandpass_envelope_follower_tb: done, errors");
        $finish;
    end

endmodule
